/* hw/rtl/isam_pkg.sv */
package isam_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int COORD_W      = 32;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } isam_op_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_FLUSH
  } isam_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] start_pos;
    logic [COORD_W-1:0] end_pos;
  } isam_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    isam_op_e   op;
    isam_item_t item;
  } isam_bus_t;

  // sequencer to merge unit
  typedef struct packed {
    logic take;
    logic flush;
    logic ovf;
  } isam_mctl_t;

endpackage

/* hw/rtl/isam_cell.sv */
module isam_cell import isam_pkg::*; (
  input  logic       clk_i,
  input  isam_bus_t  bus_i,
  input  logic       occ_i,
  input  logic       prev_place_i,
  input  isam_item_t prev_i,
  input  isam_item_t next_i,
  output isam_item_t item_o,
  output logic       place_o
);

  isam_item_t item_q, item_d;

  // strict compare keeps arrival order among equal starts
  assign place_o = !occ_i || (item_q.start_pos > bus_i.item.start_pos);

  always_comb begin
    item_d = item_q;
    case (bus_i.op)
      OP_INSERT: begin
        if (place_o) begin
          if (prev_place_i) begin
            item_d = prev_i;
          end else begin
            item_d = bus_i.item;
          end
        end
      end
      OP_POP: begin
        item_d = next_i;
      end
      default: begin
        item_d = item_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o = item_q;

endmodule

/* hw/rtl/isam_merge.sv */
module isam_merge import isam_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isam_mctl_t         ctl_i,
  input  isam_item_t         head_i,
  output logic               result_valid_o,
  output logic [COORD_W-1:0] merged_start_o,
  output logic [COORD_W-1:0] merged_end_o,
  output logic               last_out_o,
  output logic               overflow_o
);

  logic       have_q, have_d;
  logic       vld_q, vld_d;
  isam_item_t cur_q, cur_d;
  isam_item_t res_q, res_d;
  logic       last_q, last_d;
  logic       ovf_q, ovf_d;

  always_comb begin
    have_d = have_q;
    cur_d  = cur_q;
    vld_d  = 1'b0;
    res_d  = res_q;
    last_d = last_q;
    ovf_d  = ovf_q;
    if (ctl_i.take) begin
      have_d = 1'b1;
      if (!have_q) begin
        cur_d = head_i;
      end else if (head_i.start_pos < cur_q.end_pos) begin
        if (head_i.end_pos > cur_q.end_pos) begin
          cur_d.end_pos = head_i.end_pos;
        end
      end else begin
        vld_d  = 1'b1;
        res_d  = cur_q;
        last_d = 1'b0;
        ovf_d  = ctl_i.ovf;
        cur_d  = head_i;
      end
    end else if (ctl_i.flush) begin
      have_d = 1'b0;
      vld_d  = have_q;
      res_d  = cur_q;
      last_d = 1'b1;
      ovf_d  = ctl_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      have_q <= have_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    res_q  <= res_d;
    last_q <= last_d;
    ovf_q  <= ovf_d;
  end

  assign result_valid_o = vld_q;
  assign merged_start_o = res_q.start_pos;
  assign merged_end_o   = res_q.end_pos;
  assign last_out_o     = last_q;
  assign overflow_o     = ovf_q;

endmodule

/* hw/rtl/interval_sort_and_merge_unit.sv */
// channel   ports                                        handshake
// input     start_pos_i, end_pos_i, last_in_i            start & !busy
// result    merged_start_o, merged_end_o, last_out_o,    result_valid_o, one cycle
//           overflow_o
//
// an accepted interval is inserted into the chain of cells, which keeps the batch
// sorted as it arrives; closing a batch drains every stored interval through the
// merge unit and then flushes it, during which busy is high
// results are registered as the chain shifts out the interval that ends them
// reset clears the fill count, overflow flag and sequencer; no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle
module interval_sort_and_merge_unit import isam_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] start_pos_i,
  input  logic [COORD_W-1:0] end_pos_i,
  input  logic               last_in_i,
  output logic               result_valid_o,
  output logic [COORD_W-1:0] merged_start_o,
  output logic [COORD_W-1:0] merged_end_o,
  output logic               last_out_o,
  output logic               overflow_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  isam_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              accept;
  logic              full;
  isam_bus_t         bus;
  isam_mctl_t        mctl;

  isam_item_t        items [CAPACITY];
  logic              place [CAPACITY];

  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(CAPACITY));

  // next state and counters
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (last_in_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (count_q == '0) begin
          state_d = ST_LOAD;
          ovf_d   = 1'b0;
        end else begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        state_d = ST_LOAD;
        ovf_d   = 1'b0;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    bus.op   = OP_HOLD;
    bus.item = '{start_pos: start_pos_i, end_pos: end_pos_i};
    mctl     = '{take: 1'b0, flush: 1'b0, ovf: ovf_q};
    case (state_q)
      ST_LOAD: begin
        if (accept && !full) begin
          bus.op = OP_INSERT;
        end
      end
      ST_DRAIN: begin
        if (count_q != '0) begin
          bus.op    = OP_POP;
          mctl.take = 1'b1;
        end
      end
      ST_FLUSH: begin
        mctl.flush = 1'b1;
      end
      default: begin
        bus.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign busy = (state_q != ST_LOAD);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       occ;
    logic       prev_place;
    isam_item_t prev_item;
    isam_item_t next_item;

    assign occ = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_place = 1'b0;
      assign prev_item  = bus.item;
    end else begin : g_body
      assign prev_place = place[i-1];
      assign prev_item  = items[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_item = items[i];
    end else begin : g_mid
      assign next_item = items[i+1];
    end

    isam_cell u_cell (
      .clk_i       (clk_i),
      .bus_i       (bus),
      .occ_i       (occ),
      .prev_place_i(prev_place),
      .prev_i      (prev_item),
      .next_i      (next_item),
      .item_o      (items[i]),
      .place_o     (place[i])
    );
  end

  isam_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (mctl),
    .head_i        (items[0]),
    .result_valid_o(result_valid_o),
    .merged_start_o(merged_start_o),
    .merged_end_o  (merged_end_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_result_only_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q != ST_LOAD))
    else $error("result while loading");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |=> (count_q == '0) && !ovf_q && (state_q == ST_LOAD))
    else $error("batch state not cleared after flush");

  a_last_after_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_out_o) |-> $past(state_q == ST_FLUSH))
    else $error("last marker outside flush");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_in_i) |=> state_q == ST_DRAIN)
    else $error("closing transaction did not start the drain");

endmodule

/* dv/interval_merge_checker.sv */
`timescale 1ns / 1ps

module interval_merge_checker import isam_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [COORD_W-1:0] start_pos_i,
  input  logic [COORD_W-1:0] end_pos_i,
  input  logic               last_in_i,
  input  logic               result_valid_i,
  input  logic [COORD_W-1:0] merged_start_i,
  input  logic [COORD_W-1:0] merged_end_i,
  input  logic               last_out_i,
  input  logic               overflow_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic               last;
    logic               ovf;
  } merged_iv_t;

  isam_item_t  batch_store [CAPACITY];
  int unsigned batch_fill;
  logic        dropped_seen;
  merged_iv_t  expected_merges [$];

  function automatic int field_mismatch(string field, logic [COORD_W-1:0] want,
                                        logic [COORD_W-1:0] got);
    if (want === got) return 0;
    $error("%s: expected %0h, actual %0h", field, want, got);
    return 1;
  endfunction

  // sort the batch stably by start, then fold overlapping neighbors together
  function automatic void close_batch();
    isam_item_t sorted [CAPACITY];
    isam_item_t key;
    merged_iv_t cur;
    int         j;
    if (batch_fill == 0) return;
    for (int i = 0; i < batch_fill; i++) sorted[i] = batch_store[i];
    for (int i = 1; i < batch_fill; i++) begin
      key = sorted[i];
      j   = i;
      while (j > 0 && sorted[j-1].start_pos > key.start_pos) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    cur.lo   = sorted[0].start_pos;
    cur.hi   = sorted[0].end_pos;
    cur.last = 1'b0;
    cur.ovf  = dropped_seen;
    for (int i = 1; i < batch_fill; i++) begin
      // touching intervals stay apart
      if (sorted[i].start_pos < cur.hi) begin
        if (sorted[i].end_pos > cur.hi) cur.hi = sorted[i].end_pos;
      end else begin
        expected_merges.push_back(cur);
        cur.lo = sorted[i].start_pos;
        cur.hi = sorted[i].end_pos;
      end
    end
    cur.last = 1'b1;
    expected_merges.push_back(cur);
  endfunction

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    merged_iv_t want;
    if (!rst_ni) begin
      batch_fill   = 0;
      dropped_seen = 1'b0;
      expected_merges.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_merges.size() == 0) begin
          $error("merged interval %0h..%0h with no transaction pending",
                 merged_start_i, merged_end_i);
          fail_count_o++;
        end else begin
          want = expected_merges.pop_front();
          fail_count_o += field_mismatch("merged_start", want.lo, merged_start_i);
          fail_count_o += field_mismatch("merged_end", want.hi, merged_end_i);
          fail_count_o += field_mismatch("last_out", COORD_W'(want.last),
                                         COORD_W'(last_out_i));
          fail_count_o += field_mismatch("overflow", COORD_W'(want.ovf),
                                         COORD_W'(overflow_i));
        end
      end
      if (start_i && !busy_i) begin
        if (batch_fill < CAPACITY) begin
          batch_store[batch_fill].start_pos = start_pos_i;
          batch_store[batch_fill].end_pos   = end_pos_i;
          batch_fill++;
        end else begin
          dropped_seen = 1'b1;
        end
        if (last_in_i) begin
          close_batch();
          batch_fill   = 0;
          dropped_seen = 1'b0;
        end
      end
    end
    pending_o = expected_merges.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb import isam_pkg::*;;

  localparam int ITEMS       = 420;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;

  typedef enum int {
    SPAN_NARROW,
    SPAN_MID,
    SPAN_FULL,
    SPAN_EDGE
  } coord_span_e;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic [COORD_W-1:0] start_pos_i = '0;
  logic [COORD_W-1:0] end_pos_i   = '0;
  logic               last_in_i   = 1'b0;
  logic               busy;
  logic               result_valid_o;
  logic [COORD_W-1:0] merged_start_o;
  logic [COORD_W-1:0] merged_end_o;
  logic               last_out_o;
  logic               overflow_o;
  int                 fail_count;
  int                 pending;
  int                 items_sent = 0;
  int                 cycles     = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  interval_sort_and_merge_unit #(.CAPACITY(CAPACITY_DEF)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .start_pos_i    (start_pos_i),
    .end_pos_i      (end_pos_i),
    .last_in_i      (last_in_i),
    .result_valid_o (result_valid_o),
    .merged_start_o (merged_start_o),
    .merged_end_o   (merged_end_o),
    .last_out_o     (last_out_o),
    .overflow_o     (overflow_o)
  );

  interval_merge_checker #(.CAPACITY(CAPACITY_DEF)) merge_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .start_pos_i    (start_pos_i),
    .end_pos_i      (end_pos_i),
    .last_in_i      (last_in_i),
    .result_valid_i (result_valid_o),
    .merged_start_i (merged_start_o),
    .merged_end_i   (merged_end_o),
    .last_out_i     (last_out_o),
    .overflow_i     (overflow_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // holds the transaction until an edge with busy low takes it
  task automatic send_interval(input logic [COORD_W-1:0] s, input logic [COORD_W-1:0] e,
                               input logic last);
    start       <= 1'b1;
    start_pos_i <= s;
    end_pos_i   <= e;
    last_in_i   <= last;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic idle_gap(input bit burst);
    int unsigned len;
    len = 0;
    if (!burst) begin
      case ($urandom_range(0, 19))
        0, 1:    len = $urandom_range(8, 40);
        default: len = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
      endcase
    end
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(coord_span_e span);
    case (span)
      SPAN_NARROW: return $urandom_range(0, 63);
      SPAN_MID:    return $urandom_range(0, 4095);
      SPAN_FULL:   return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return 32'h1;
          2:       return 32'hFFFF_FFFE;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_batch(input int n, input coord_span_e span, input bit burst);
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] e;
    for (int i = 0; i < n; i++) begin
      s = pick_coord(span);
      // mostly forward intervals, some reversed or unrelated
      if ($urandom_range(0, 4) != 0 && span != SPAN_EDGE)
        e = s + ((span == SPAN_FULL) ? $urandom() >> $urandom_range(0, 31)
                                     : $urandom_range(0, 24));
      else
        e = pick_coord(span);
      send_interval(s, e, i == n - 1);
      idle_gap(burst);
    end
  endtask

  initial begin
    int          batch_no;
    int          n;
    coord_span_e span;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-interval batches at the coordinate extremes, one reversed
    send_interval(32'h0, 32'hFFFF_FFFF, 1'b1);
    send_interval(32'hFFFF_FFFF, 32'h0, 1'b1);
    // arrives unsorted, touching ends do not merge
    send_interval(32'd20, 32'd30, 1'b0);
    send_interval(32'd10, 32'd20, 1'b1);
    idle_gap(1'b0);
    // equal starts keep arrival order, which changes the outcome
    send_interval(32'd5, 32'd5, 1'b0);
    send_interval(32'd5, 32'd9, 1'b1);
    send_interval(32'd5, 32'd9, 1'b0);
    send_interval(32'd5, 32'd5, 1'b1);
    // reversed intervals inside an overlapping chain
    send_interval(32'd100, 32'd50, 1'b0);
    send_interval(32'd40, 32'd120, 1'b0);
    send_interval(32'd110, 32'd90, 1'b0);
    send_interval(32'd200, 32'd300, 1'b0);
    send_interval(32'd0, 32'd1, 1'b1);
    idle_gap(1'b0);
    // containment and extension of the running interval
    send_interval(32'd0, 32'd1000, 1'b0);
    send_interval(32'd10, 32'd20, 1'b0);
    send_interval(32'd30, 32'd2000, 1'b0);
    send_interval(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_interval(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);

    batch_no = 0;
    while (items_sent < ITEMS) begin
      if (batch_no == 2 || batch_no == 9)
        n = CAPACITY_DEF + $urandom_range(1, 3);
      else if (batch_no == 5)
        n = CAPACITY_DEF;
      else if ($urandom_range(0, 9) == 0)
        n = $urandom_range(13, 40);
      else
        n = $urandom_range(1, 12);
      span = coord_span_e'($urandom_range(0, 3));
      send_batch(n, span, $urandom_range(0, 9) < 3);
      batch_no++;
    end
    start <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* interval_sort_and_merge_unit.f */
hw/rtl/isam_pkg.sv
hw/rtl/isam_cell.sv
hw/rtl/isam_merge.sv
hw/rtl/interval_sort_and_merge_unit.sv
dv/interval_merge_checker.sv
dv/tb.sv
